// ===== hdl/ips_pkg.sv =====
// Shared types and codes for the indexed priority scheduler.
`default_nettype none

package ips_pkg;

  localparam int PRIO_W    = 32;
  localparam int PAYLOAD_W = 32;
  localparam int ID_W      = 6;

  typedef enum logic [1:0] {
    OP_ADD      = 2'd0,
    OP_UPDATE   = 2'd1,
    OP_POP      = 2'd2,
    OP_CONTAINS = 2'd3
  } op_t;

  // One table slot as held in the memory.
  typedef struct packed {
    logic                     valid;
    logic signed [PRIO_W-1:0] prio;
    logic [PAYLOAD_W-1:0]     payload;
  } entry_t;

  // Controls from the sequencer to the best-entry tracker.
  typedef struct packed {
    logic start;
    logic sample;
    logic min_first;
  } scan_ctl_t;

endpackage

`default_nettype wire

// ===== hdl/ips_mem.sv =====
// Task table memory: one write port, one registered read port.
`default_nettype none

module ips_mem
  import ips_pkg::*;
#(
  parameter int DEPTH  = 64,
  parameter int ADDR_W = 6
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire entry_t            wr_data,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output entry_t                 rd_data
);

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== hdl/ips_best.sv =====
// Running best-entry tracker fed by the table scan.
`default_nettype none

module ips_best
  import ips_pkg::*;
#(
  parameter int IDX_W = 6
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire scan_ctl_t                ctl,
  input  wire logic [IDX_W-1:0]         sample_idx,
  input  wire entry_t                   sample,
  output logic                          found,
  output logic [IDX_W-1:0]              best_idx,
  output logic signed [PRIO_W-1:0]      best_prio,
  output logic [PAYLOAD_W-1:0]          best_payload
);

  logic beats;
  logic take;

  // strict compare so that ties keep the lower id seen first
  always_comb begin
    if (ctl.min_first) begin
      beats = $signed(sample.prio) < $signed(best_prio);
    end else begin
      beats = $signed(sample.prio) > $signed(best_prio);
    end
    take = ctl.sample && sample.valid && (!found || beats);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      found <= 1'b0;
    end else if (ctl.start) begin
      found <= 1'b0;
    end else if (take) begin
      found <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      best_idx     <= sample_idx;
      best_prio    <= sample.prio;
      best_payload <= sample.payload;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/indexed_priority_scheduler_core.sv =====
// Top level: sequencer, config register and output register of the scheduler.
//
//  port group     dir  handshake          contents
//  cfg_*          in   cfg_we             min_first
//  in_* / fields  in   in_valid/in_stall  operation, task_id, task_priority, task_payload
//  out_* / fields out  out_valid/out_stall ok, result_id, result_priority, result_payload
//
// Add, update and contains: accept with table read, then check and write back.
// Pop: one table read per slot, then the best slot is cleared.
// After reset a clearing pass writes every slot; in_stall stays high until it ends.
// Only one word is in flight; a finished result waits in the output register under
// out_stall, and the next input word is taken meanwhile.
`default_nettype none

module indexed_priority_scheduler_core
  import ips_pkg::*;
#(
  parameter int ENTRIES = 64
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_we,
  input  wire logic                   cfg_wdata,
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire logic [1:0]             operation,
  input  wire logic [ID_W-1:0]        task_id,
  input  wire logic signed [PRIO_W-1:0] task_priority,
  input  wire logic [PAYLOAD_W-1:0]   task_payload,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic                        ok,
  output logic [ID_W-1:0]             result_id,
  output logic signed [PRIO_W-1:0]    result_priority,
  output logic [PAYLOAD_W-1:0]        result_payload
);

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int EXT_W = IDX_W + ID_W;
  localparam logic [IDX_W-1:0] LAST = IDX_W'(ENTRIES - 1);

  typedef enum logic [5:0] {
    ST_CLEAR   = 6'b000001,
    ST_IDLE    = 6'b000010,
    ST_LOOKUP  = 6'b000100,
    ST_SCAN    = 6'b001000,
    ST_DRAIN   = 6'b010000,
    ST_RESOLVE = 6'b100000
  } state_t;

  state_t state, state_next;

  logic                     min_first;
  logic [IDX_W-1:0]         cnt;
  op_t                      op_r;
  logic [IDX_W-1:0]         id_r;
  logic                     in_range_r;
  logic signed [PRIO_W-1:0] prio_r;
  logic [PAYLOAD_W-1:0]     pay_r;
  logic                     sample_valid;
  logic [IDX_W-1:0]         sample_idx;

  logic [EXT_W-1:0]         id_ext;
  logic [EXT_W-1:0]         best_ext;
  logic [IDX_W-1:0]         id_addr;
  logic                     in_range_now;
  logic                     in_acc;
  logic                     out_free;
  logic                     finishing;
  logic                     present;

  logic                     rd_en;
  logic [IDX_W-1:0]         rd_addr;
  entry_t                   rd_data;
  logic                     wr_en;
  logic [IDX_W-1:0]         wr_addr;
  entry_t                   wr_data;

  logic                     ok_next;
  logic [ID_W-1:0]          rid_next;
  logic signed [PRIO_W-1:0] rprio_next;
  logic [PAYLOAD_W-1:0]     rpay_next;

  scan_ctl_t                scan_ctl;
  logic                     found;
  logic [IDX_W-1:0]         best_idx;
  logic signed [PRIO_W-1:0] best_prio;
  logic [PAYLOAD_W-1:0]     best_payload;

  assign id_ext       = EXT_W'(task_id);
  assign id_addr      = id_ext[IDX_W-1:0];
  assign in_range_now = 32'(task_id) < 32'(ENTRIES);
  assign best_ext     = EXT_W'(best_idx);

  assign in_stall  = (state != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign finishing = ((state == ST_LOOKUP) || (state == ST_RESOLVE)) && out_free;
  assign present   = in_range_r && rd_data.valid;

  // config register
  always_ff @(posedge clk) begin
    if (rst) begin
      min_first <= 1'b0;
    end else if (cfg_we) begin
      min_first <= cfg_wdata;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR:   if (cnt == LAST) state_next = ST_IDLE;
      ST_IDLE: begin
        if (in_acc) begin
          state_next = (op_t'(operation) == OP_POP) ? ST_SCAN : ST_LOOKUP;
        end
      end
      ST_SCAN:    if (cnt == LAST) state_next = ST_DRAIN;
      ST_DRAIN:   state_next = ST_RESOLVE;
      ST_LOOKUP:  if (out_free) state_next = ST_IDLE;
      ST_RESOLVE: if (out_free) state_next = ST_IDLE;
      default:    state_next = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_CLEAR;
      cnt          <= '0;
      sample_valid <= 1'b0;
    end else begin
      state        <= state_next;
      sample_valid <= (state == ST_SCAN);
      if ((state == ST_CLEAR) || (state == ST_SCAN)) begin
        cnt <= (cnt == LAST) ? '0 : cnt + 1'b1;
      end else begin
        cnt <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    sample_idx <= cnt;
    if (in_acc) begin
      op_r       <= op_t'(operation);
      id_r       <= id_addr;
      in_range_r <= in_range_now;
      prio_r     <= task_priority;
      pay_r      <= task_payload;
    end
  end

  // Reads happen only at accept and during the scan; writes, apart from the clearing
  // pass, only after the read data is back, so an access never meets a write to the same slot.
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = cnt;
    if (in_acc) begin
      rd_en   = 1'b1;
      rd_addr = id_addr;
    end else if (state == ST_SCAN) begin
      rd_en   = 1'b1;
    end
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = id_r;
    wr_data = '0;
    ok_next    = 1'b0;
    rid_next   = '0;
    rprio_next = '0;
    rpay_next  = '0;
    case (state)
      ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = cnt;
      end
      ST_LOOKUP: begin
        case (op_r)
          OP_ADD: begin
            ok_next = in_range_r && !rd_data.valid;
            wr_data = '{valid: 1'b1, prio: prio_r, payload: pay_r};
          end
          OP_UPDATE: begin
            ok_next = present;
            wr_data = '{valid: 1'b1, prio: prio_r, payload: rd_data.payload};
          end
          OP_CONTAINS: ok_next = present;
          default:     ok_next = 1'b0;
        endcase
        wr_en = out_free && ok_next && (op_r != OP_CONTAINS);
      end
      ST_RESOLVE: begin
        ok_next = found;
        if (found) begin
          rid_next   = best_ext[ID_W-1:0];
          rprio_next = best_prio;
          rpay_next  = best_payload;
        end
        wr_en   = out_free && found;
        wr_addr = best_idx;
        wr_data = '{valid: 1'b0, prio: best_prio, payload: best_payload};
      end
      default: wr_en = 1'b0;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (finishing) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finishing) begin
      ok              <= ok_next;
      result_id       <= rid_next;
      result_priority <= rprio_next;
      result_payload  <= rpay_next;
    end
  end

  assign scan_ctl = '{
    start:     in_acc && (op_t'(operation) == OP_POP),
    sample:    sample_valid,
    min_first: min_first
  };

  ips_mem #(
    .DEPTH  (ENTRIES),
    .ADDR_W (IDX_W)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  ips_best #(
    .IDX_W (IDX_W)
  ) u_best (
    .clk          (clk),
    .rst          (rst),
    .ctl          (scan_ctl),
    .sample_idx   (sample_idx),
    .sample       (rd_data),
    .found        (found),
    .best_idx     (best_idx),
    .best_prio    (best_prio),
    .best_payload (best_payload)
  );

  a_accept_starts_work: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> (state == ST_LOOKUP) || (state == ST_SCAN))
    else $error("accepted word did not start a lookup or scan");

  a_no_write_while_reading: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) || (state == ST_SCAN) || (state == ST_DRAIN) |-> !wr_en)
    else $error("table write overlaps a read phase");

  a_pop_clears_slot: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RESOLVE) && out_free && found |-> wr_en && !wr_data.valid
      && (wr_addr == best_idx))
    else $error("popped slot not cleared");

  a_fail_result_zero: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) && !ok |-> (result_id == '0) && (result_priority == '0)
      && (result_payload == '0))
    else $error("refused word carries nonzero task fields");

endmodule

`default_nettype wire
